/* hdl/lswc_pkg.sv */
// Shared types and constants for the line segment window clipper.
// Holds the segment and piece payload structs, outcode bits and register indexes.
`timescale 1ns / 1ps
`default_nettype none
package lswc_pkg;
	localparam int CoordW = 16;
	localparam int CfgIdxW = 2;

	localparam logic [3:0] OcLeft   = 4'd8;
	localparam logic [3:0] OcTop    = 4'd4;
	localparam logic [3:0] OcRight  = 4'd2;
	localparam logic [3:0] OcBottom = 4'd1;

	localparam logic [CfgIdxW-1:0] RegLeft   = 2'd0;
	localparam logic [CfgIdxW-1:0] RegRight  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegBottom = 2'd2;
	localparam logic [CfgIdxW-1:0] RegTop    = 2'd3;

	localparam logic signed [CoordW-1:0] ResetLeft   = 16'sd768;
	localparam logic signed [CoordW-1:0] ResetRight  = 16'sd1792;
	localparam logic signed [CoordW-1:0] ResetBottom = 16'sd768;
	localparam logic signed [CoordW-1:0] ResetTop    = 16'sd1536;

	localparam int MaxClipSteps = 8;

	typedef struct packed {
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
	} segment_t;

	typedef struct packed {
		logic signed [CoordW-1:0] piece_x0;
		logic signed [CoordW-1:0] piece_y0;
		logic signed [CoordW-1:0] piece_x1;
		logic signed [CoordW-1:0] piece_y1;
		logic                     inside_piece;
		logic                     last_piece;
	} piece_t;
endpackage
`default_nettype wire

/* hdl/line_segment_window_clipper.sv */
// Cohen-Sutherland line clipper: sequencer, shared multiplier and radix-2 divider.
// Depends on lswc_pkg for payload structs, outcode bits and register indexes.
//
// Channel | Signals                          | Direction
// --------+----------------------------------+----------
// in      | in_valid, in_ready, in_data      | input segment
// out     | out_valid, out_ready, out_data   | clipped pieces (1 to 3)
// cfg     | cfg_we, cfg_index, cfg_data      | window edges, write only
//
// Each clip step runs select, multiply, one restoring divider cycle per product bit,
// then update. A segment holds the sequencer for its clip steps, one decision and
// three output slots; a slot is stretched while its piece waits on out_ready.
// in_ready is high only while the sequencer is idle.
// Reset clears control state and loads the default window.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_window_clipper (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  lswc_pkg::segment_t                 in_data,
	output logic                               out_valid,
	input  wire                                out_ready,
	output lswc_pkg::piece_t                   out_data,
	input  wire                                cfg_we,
	input  wire  [lswc_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire  [lswc_pkg::CoordW-1:0]        cfg_data
);
	localparam int W    = lswc_pkg::CoordW;
	localparam int W1   = W + 1;
	localparam int PW   = 2 * W1;
	localparam int CntW = $clog2(PW + 1);
	localparam int StW  = $clog2(lswc_pkg::MaxClipSteps + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;

	logic signed [W-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;
	lswc_pkg::segment_t  seg_q;
	logic signed [W-1:0] px_q [2];
	logic signed [W-1:0] py_q [2];
	logic [StW-1:0]      step_q;
	logic                acc_q;
	logic                m_q, xaxis_q, neg_q, zero_q;
	logic signed [W-1:0] edge_q;
	logic [W1-1:0]       mag_a_q, mag_b_q, mag_c_q;
	logic [PW-1:0]       dvd_q;
	logic [W1:0]         rem_q;
	logic [W-1:0]        quo_q;
	logic [CntW-1:0]     cnt_q;
	logic [1:0]          k_q;
	lswc_pkg::piece_t    out_q;
	logic                out_valid_q;

	function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
	                                       input logic signed [W-1:0] y,
	                                       input logic signed [W-1:0] wl,
	                                       input logic signed [W-1:0] wr,
	                                       input logic signed [W-1:0] wb,
	                                       input logic signed [W-1:0] wt);
		logic [3:0] c;
		c = 4'd0;
		if (x < wl) c = c | lswc_pkg::OcLeft;
		if (y > wt) c = c | lswc_pkg::OcTop;
		if (x > wr) c = c | lswc_pkg::OcRight;
		if (y < wb) c = c | lswc_pkg::OcBottom;
		return c;
	endfunction

	function automatic logic [W1-1:0] magn(input logic signed [W1-1:0] v);
		return v[W1-1] ? W1'(-v) : W1'(v);
	endfunction

	// codes of the current endpoints
	logic [3:0] code0, code1, cm;
	logic       mm, mo;
	always_comb begin
		code0 = outcode(px_q[0], py_q[0], win_left_q, win_right_q, win_bottom_q, win_top_q);
		code1 = outcode(px_q[1], py_q[1], win_left_q, win_right_q, win_bottom_q, win_top_q);
		mm    = (code0 == 4'd0);
		mo    = ~mm;
		cm    = mm ? code1 : code0;
	end

	// operand selection for one clip step
	logic                xsel;
	logic signed [W-1:0] esel;
	logic signed [W1-1:0] op_a, op_b, op_c;
	always_comb begin
		xsel = 1'b1;
		esel = win_top_q;
		priority if ((cm & lswc_pkg::OcLeft) != 4'd0) begin
			esel = win_left_q;
		end else if ((cm & lswc_pkg::OcRight) != 4'd0) begin
			esel = win_right_q;
		end else if ((cm & lswc_pkg::OcBottom) != 4'd0) begin
			xsel = 1'b0;
			esel = win_bottom_q;
		end else begin
			xsel = 1'b0;
			esel = win_top_q;
		end
		if (xsel) begin
			op_a = W1'(esel) - W1'(px_q[mm]);
			op_b = W1'(py_q[mo]) - W1'(py_q[mm]);
			op_c = W1'(px_q[mo]) - W1'(px_q[mm]);
		end else begin
			op_a = W1'(esel) - W1'(py_q[mm]);
			op_b = W1'(px_q[mo]) - W1'(px_q[mm]);
			op_c = W1'(py_q[mo]) - W1'(py_q[mm]);
		end
	end

	// one restoring divider step
	logic [W1:0] rem_sh;
	logic        qbit;
	always_comb begin
		rem_sh = {rem_q[W1-1:0], dvd_q[PW-1]};
		qbit   = (rem_sh >= {1'b0, mag_c_q});
	end

	logic [W-1:0]        term;
	logic signed [W-1:0] base_c, new_c;
	logic                mv0, mv1, slot_free;
	lswc_pkg::piece_t    piece;
	logic                piece_ok;
	always_comb begin
		term   = zero_q ? '0 : (neg_q ? W'(-quo_q) : quo_q);
		base_c = xaxis_q ? py_q[m_q] : px_q[m_q];
		new_c  = W'(base_c + $signed(term));

		mv0 = (px_q[0] != seg_q.start_x) || (py_q[0] != seg_q.start_y);
		mv1 = (px_q[1] != seg_q.end_x) || (py_q[1] != seg_q.end_y);
		slot_free = ~out_valid_q | out_ready;
		piece = '0;
		piece_ok = 1'b0;
		unique case (k_q)
			2'd0: begin
				piece_ok = acc_q & mv0;
				piece = '{seg_q.start_x, seg_q.start_y, px_q[0], py_q[0], 1'b0, 1'b0};
			end
			2'd1: begin
				piece_ok = acc_q & mv1;
				piece = '{seg_q.end_x, seg_q.end_y, px_q[1], py_q[1], 1'b0, 1'b0};
			end
			default: begin
				piece_ok = 1'b1;
				if (acc_q)
					piece = '{px_q[0], py_q[0], px_q[1], py_q[1], 1'b1, 1'b1};
				else
					piece = '{seg_q.start_x, seg_q.start_y, seg_q.end_x, seg_q.end_y,
					          1'b0, 1'b1};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= lswc_pkg::ResetLeft;
			win_right_q  <= lswc_pkg::ResetRight;
			win_bottom_q <= lswc_pkg::ResetBottom;
			win_top_q    <= lswc_pkg::ResetTop;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lswc_pkg::RegLeft:   win_left_q   <= cfg_data;
				lswc_pkg::RegRight:  win_right_q  <= cfg_data;
				lswc_pkg::RegBottom: win_bottom_q <= cfg_data;
				default:             win_top_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			acc_q       <= 1'b0;
		end else begin
			// load the next piece into a free slot, else drop valid once taken
			if (state_q == S_OUT && slot_free)
				out_valid_q <= piece_ok;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_STEP;
						step_q  <= '0;
					end
				end
				S_STEP: begin
					priority if (step_q == StW'(lswc_pkg::MaxClipSteps)) begin
						acc_q   <= 1'b0;
						k_q     <= '0;
						state_q <= S_OUT;
					end else if ((code0 | code1) == 4'd0) begin
						acc_q   <= 1'b1;
						k_q     <= '0;
						state_q <= S_OUT;
					end else if ((code0 & code1) != 4'd0) begin
						acc_q   <= 1'b0;
						k_q     <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(PW - 1)) state_q <= S_UPD;
				end
				S_UPD: begin
					step_q  <= step_q + 1'b1;
					state_q <= S_STEP;
				end
				S_OUT: begin
					if (slot_free) begin
						k_q <= k_q + 1'b1;
						if (k_q == 2'd2) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					seg_q    <= in_data;
					px_q[0]  <= in_data.start_x;
					py_q[0]  <= in_data.start_y;
					px_q[1]  <= in_data.end_x;
					py_q[1]  <= in_data.end_y;
				end
			end
			S_STEP: begin
				m_q     <= mm;
				xaxis_q <= xsel;
				edge_q  <= esel;
				mag_a_q <= magn(op_a);
				mag_b_q <= magn(op_b);
				mag_c_q <= magn(op_c);
				neg_q   <= op_a[W1-1] ^ op_b[W1-1] ^ op_c[W1-1];
				zero_q  <= (op_c == '0);
			end
			S_MUL: begin
				dvd_q <= mag_a_q * mag_b_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				dvd_q <= {dvd_q[PW-2:0], 1'b0};
				rem_q <= qbit ? rem_sh - {1'b0, mag_c_q} : rem_sh;
				quo_q <= {quo_q[W-2:0], qbit};
			end
			S_UPD: begin
				if (xaxis_q) begin
					px_q[m_q] <= edge_q;
					py_q[m_q] <= new_c;
				end else begin
					py_q[m_q] <= edge_q;
					px_q[m_q] <= new_c;
				end
			end
			S_OUT: begin
				if (slot_free && piece_ok) out_q <= piece;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after a transaction");
	a_inside_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_piece |-> out_data.last_piece)
		else $error("inside piece not marked last");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= StW'(lswc_pkg::MaxClipSteps))
		else $error("clip step count overran");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && slot_free && k_q == 2'd2 |=> out_valid && out_data.last_piece)
		else $error("final piece not loaded");
endmodule
`default_nettype wire

/* dv/tb_line_segment_window_clipper.sv */
// Self-checking testbench for the line segment window clipper.
// Drives segments and window edges, predicts the clipped pieces, checks each one.
// Depends on lswc_pkg and the line_segment_window_clipper top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_line_segment_window_clipper;
	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 60;
	localparam int RandPerPhase = 76;
	localparam int CW = lswc_pkg::CoordW;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	lswc_pkg::segment_t            in_data;
	logic                          out_valid;
	logic                          out_ready;
	lswc_pkg::piece_t              out_data;
	logic                          cfg_we;
	logic [lswc_pkg::CfgIdxW-1:0]  cfg_index;
	logic [CW-1:0]                 cfg_data;

	line_segment_window_clipper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		lswc_pkg::segment_t seg;
		bit                 typed;
		lswc_pkg::piece_t   piece;
	} stim_row_t;

	logic signed [CW-1:0] win_left, win_right, win_bottom, win_top;
	lswc_pkg::piece_t pieces_due[$];
	int errors = 0;
	int segments_sent = 0;
	int pieces_seen = 0;
	int inside_seen = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d pieces pending", cycle_count,
				pieces_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic report(string field, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (piece %0d)", field, got, want,
			pieces_seen);
	endtask

	always @(posedge clk) begin
		lswc_pkg::piece_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pieces_due.size() == 0) begin
				report("unexpected piece", out_data.piece_x0, 0);
			end else begin
				want = pieces_due.pop_front();
				if (out_data.piece_x0 !== want.piece_x0)
					report("piece_x0", out_data.piece_x0, want.piece_x0);
				if (out_data.piece_y0 !== want.piece_y0)
					report("piece_y0", out_data.piece_y0, want.piece_y0);
				if (out_data.piece_x1 !== want.piece_x1)
					report("piece_x1", out_data.piece_x1, want.piece_x1);
				if (out_data.piece_y1 !== want.piece_y1)
					report("piece_y1", out_data.piece_y1, want.piece_y1);
				if (out_data.inside_piece !== want.inside_piece)
					report("inside_piece", out_data.inside_piece, want.inside_piece);
				if (out_data.last_piece !== want.last_piece)
					report("last_piece", out_data.last_piece, want.last_piece);
				if (want.inside_piece)
					inside_seen++;
			end
			pieces_seen++;
		end
	end

	function automatic longint wrap_coord(longint v);
		logic signed [CW-1:0] t;
		t = CW'(v);
		return t;
	endfunction

	function automatic logic [3:0] region_code(longint x, longint y);
		logic [3:0] c;
		c = '0;
		if (x < win_left) c |= lswc_pkg::OcLeft;
		if (y > win_top) c |= lswc_pkg::OcTop;
		if (x > win_right) c |= lswc_pkg::OcRight;
		if (y < win_bottom) c |= lswc_pkg::OcBottom;
		return c;
	endfunction

	// a*b/c, truncated toward zero; zero divisor gives zero
	function automatic longint interp(longint a, longint b, longint c);
		if (c == 0)
			return 0;
		return (a * b) / c;
	endfunction

	function automatic lswc_pkg::piece_t make_piece(longint xa, longint ya, longint xb,
			longint yb, bit in_win, bit last);
		lswc_pkg::piece_t p;
		p.piece_x0 = CW'(xa);
		p.piece_y0 = CW'(ya);
		p.piece_x1 = CW'(xb);
		p.piece_y1 = CW'(yb);
		p.inside_piece = in_win;
		p.last_piece = last;
		return p;
	endfunction

	task automatic predict_pieces(lswc_pkg::segment_t s);
		longint px[2], py[2], nx, ny;
		logic [3:0] code[2];
		logic [3:0] c;
		bit accepted;
		int m, o;
		px[0] = s.start_x; py[0] = s.start_y;
		px[1] = s.end_x;   py[1] = s.end_y;
		code[0] = region_code(px[0], py[0]);
		code[1] = region_code(px[1], py[1]);
		accepted = 0;
		for (int step = 0; step < lswc_pkg::MaxClipSteps; step++) begin
			if ((code[0] | code[1]) == 0) begin
				accepted = 1;
				break;
			end
			if ((code[0] & code[1]) != 0)
				break;
			m = (code[0] != 0) ? 0 : 1;
			o = 1 - m;
			c = code[m];
			if (c & lswc_pkg::OcLeft) begin
				nx = win_left;
				ny = py[m] + interp(win_left - px[m], py[o] - py[m], px[o] - px[m]);
			end else if (c & lswc_pkg::OcRight) begin
				nx = win_right;
				ny = py[m] + interp(win_right - px[m], py[o] - py[m], px[o] - px[m]);
			end else if (c & lswc_pkg::OcBottom) begin
				ny = win_bottom;
				nx = px[m] + interp(win_bottom - py[m], px[o] - px[m], py[o] - py[m]);
			end else begin
				ny = win_top;
				nx = px[m] + interp(win_top - py[m], px[o] - px[m], py[o] - py[m]);
			end
			px[m] = wrap_coord(nx);
			py[m] = wrap_coord(ny);
			code[m] = region_code(px[m], py[m]);
		end
		if (!accepted) begin
			pieces_due.push_back(make_piece(s.start_x, s.start_y, s.end_x, s.end_y, 0, 1));
		end else begin
			if (px[0] != s.start_x || py[0] != s.start_y)
				pieces_due.push_back(make_piece(s.start_x, s.start_y, px[0], py[0], 0, 0));
			if (px[1] != s.end_x || py[1] != s.end_y)
				pieces_due.push_back(make_piece(s.end_x, s.end_y, px[1], py[1], 0, 0));
			pieces_due.push_back(make_piece(px[0], py[0], px[1], py[1], 1, 1));
		end
	endtask

	// Hold valid across back-to-back transactions; drop it only for a gap.
	task automatic send_segment(lswc_pkg::segment_t s, bit typed, lswc_pkg::piece_t piece);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		if (typed)
			pieces_due.push_back(piece);
		else
			predict_pieces(s);
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
		segments_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pieces_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_edge(logic [lswc_pkg::CfgIdxW-1:0] idx, logic signed [CW-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lswc_pkg::RegLeft:   win_left = v;
			lswc_pkg::RegRight:  win_right = v;
			lswc_pkg::RegBottom: win_bottom = v;
			default:             win_top = v;
		endcase
	endtask

	task automatic set_window(longint l, longint r, longint b, longint t);
		wait_idle();
		write_edge(lswc_pkg::RegLeft, CW'(l));
		write_edge(lswc_pkg::RegRight, CW'(r));
		write_edge(lswc_pkg::RegBottom, CW'(b));
		write_edge(lswc_pkg::RegTop, CW'(t));
	endtask

	function automatic longint near_window(longint lo, longint hi);
		longint a, b;
		a = (lo < hi ? lo : hi) - 1536;
		b = (lo < hi ? hi : lo) + 1536;
		return wrap_coord(a + longint'($urandom_range(int'(b - a))));
	endfunction

	function automatic lswc_pkg::segment_t random_segment();
		lswc_pkg::segment_t s;
		int pick;
		pick = $urandom_range(99);
		if (pick < 65) begin
			s.start_x = CW'(near_window(win_left, win_right));
			s.start_y = CW'(near_window(win_bottom, win_top));
			s.end_x = CW'(near_window(win_left, win_right));
			s.end_y = CW'(near_window(win_bottom, win_top));
		end else if (pick < 85) begin
			s = {$urandom, $urandom};
		end else begin
			// snap the start x and end y coordinates onto window edges
			s.start_x = $urandom_range(1) ? win_left : win_right;
			s.start_y = CW'(near_window(win_bottom, win_top));
			s.end_x = CW'(near_window(win_left, win_right));
			s.end_y = $urandom_range(1) ? win_bottom : win_top;
		end
		return s;
	endfunction

	task automatic random_phase(int count, bit pause_once);
		lswc_pkg::piece_t none;
		none = '0;
		for (int i = 0; i < count; i++) begin
			if (pause_once && i == count / 2) begin
				in_valid <= 1'b0;
				while (pieces_due.size() != 0)
					@(posedge clk);
			end
			send_segment(random_segment(), 0, none);
		end
	endtask

	stim_row_t directed[$];

	initial begin
		longint l, r, b, t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		win_left = lswc_pkg::ResetLeft;
		win_right = lswc_pkg::ResetRight;
		win_bottom = lswc_pkg::ResetBottom;
		win_top = lswc_pkg::ResetTop;

		// inside, rejects and extremes against the reset window
		directed.push_back('{'{1024, 1024, 1280, 1280}, 1,
			make_piece(1024, 1024, 1280, 1280, 1, 1)});
		directed.push_back('{'{0, 0, 256, 1024}, 1, make_piece(0, 0, 256, 1024, 0, 1)});
		directed.push_back('{'{32767, 32767, 32767, 32767}, 1,
			make_piece(32767, 32767, 32767, 32767, 0, 1)});
		directed.push_back('{'{-32768, -32768, -32768, -32768}, 1,
			make_piece(-32768, -32768, -32768, -32768, 0, 1)});
		directed.push_back('{'{768, 768, 1792, 1536}, 1,
			make_piece(768, 768, 1792, 1536, 1, 1)});
		directed.push_back('{'{1280, 1280, 1280, 1280}, 1,
			make_piece(1280, 1280, 1280, 1280, 1, 1)});
		directed.push_back('{'{-32768, -32768, 32767, 32767}, 0, '0});
		directed.push_back('{'{32767, -32768, -32768, 32767}, 0, '0});
		directed.push_back('{'{0, 1024, 1024, 1024}, 0, '0});
		directed.push_back('{'{1024, 1024, 4096, 1024}, 0, '0});
		directed.push_back('{'{1024, 0, 1024, 4096}, 0, '0});
		directed.push_back('{'{1024, 4096, 1024, 0}, 0, '0});
		directed.push_back('{'{0, 0, 4096, 4096}, 0, '0});
		directed.push_back('{'{4096, 4096, 0, 0}, 0, '0});
		// clipped start lands past the corner, rejected on the next step
		directed.push_back('{'{256, 1024, 1024, 2048}, 0, '0});
		directed.push_back('{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555}, 0, '0});
		directed.push_back('{'{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA}, 0, '0});
		directed.push_back('{'{-5, 1100, 1500, -7}, 0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_segment(directed[i].seg, directed[i].typed, directed[i].piece);

		send_idle_pct = 6;
		recv_stall_pct = 87;
		random_phase(RandPerPhase, 1);

		set_window(-32768, 32767, -32768, 32767);
		random_phase(RandPerPhase / 2, 0);

		send_idle_pct = 87;
		recv_stall_pct = 6;
		// inverted window exercises the step limit
		set_window(1792, 768, 1536, 768);
		random_phase(RandPerPhase / 2, 0);

		set_window(0, 0, 0, 0);
		random_phase(RandPerPhase / 2, 0);

		set_window(32767, 32767, -32768, -32768);
		random_phase(RandPerPhase / 2, 0);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < 4; k++) begin
			l = $signed(16'($urandom_range(8192))) - 4096;
			r = l + $urandom_range(6000);
			b = $signed(16'($urandom_range(8192))) - 4096;
			t = b + $urandom_range(6000);
			set_window(wrap_coord(l), wrap_coord(r), wrap_coord(b), wrap_coord(t));
			random_phase(RandPerPhase / 2 + 5, k == 2);
		end

		wait_idle();
		$display("covered %0d segments, %0d pieces (%0d inside) over 9 window settings",
			segments_sent, pieces_seen, inside_seen);
		$display("including inverted, degenerate and full-range windows; %0d mismatches",
			errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
